// File: sv/cst_pkg.sv
// Shared widths, codes and types of the triangle stiffness pipeline.
`default_nettype none

package cst_pkg;

    // Field and datapath widths.
    localparam int CoordW = 32;
    localparam int DiffW  = 33;
    localparam int ProdW  = 66;
    localparam int DetW   = 67;
    localparam int AbsW   = 66;
    localparam int D1W    = 83;
    localparam int DenW   = 102;
    localparam int HeW    = 64;
    localparam int CoefW  = 17;
    localparam int VrW    = 16;
    localparam int TermW  = 84;
    localparam int SumW   = 84;
    localparam int MagW   = 84;
    localparam int LoW    = 117;
    localparam int NumW   = 150;
    localparam int NxW    = 151;
    localparam int DivW   = 103;
    localparam int QuoW   = 47;
    localparam int ValW   = 48;
    localparam int IdxW   = 3;

    localparam logic [CoefW-1:0] OneQ  = 17'd65536;
    localparam logic [VrW-1:0]   HalfQ = 16'd32768;

    localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
    localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [IdxW-1:0] CfgModApical = 3'd0;
    localparam logic [IdxW-1:0] CfgModBasal  = 3'd1;
    localparam logic [IdxW-1:0] CfgModMid    = 3'd2;
    localparam logic [IdxW-1:0] CfgPoisson   = 3'd3;
    localparam logic [IdxW-1:0] CfgHeight    = 3'd4;

    // Placement codes.
    localparam logic [1:0] PlaceBasal  = 2'd0;
    localparam logic [1:0] PlaceApical = 2'd1;

    // Last degree of freedom of a row or column.
    localparam logic [IdxW-1:0] DofLast = 3'd5;

    typedef struct packed {
        logic [CoordW-1:0] mod_apical;
        logic [CoordW-1:0] mod_basal;
        logic [CoordW-1:0] mod_mid;
        logic [VrW-1:0]    poisson;
        logic [CoordW-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [2:0][CoordW-1:0] x;
        logic [2:0][CoordW-1:0] y;
        logic [1:0]             placement;
    } t_tri;

    // Per-element quantities shared by all 36 entries.
    typedef struct packed {
        logic [2:0][DiffW-1:0] b;
        logic [2:0][DiffW-1:0] c;
        logic [HeW-1:0]        he;
        logic [CoefW-1:0]      umv;
        logic [VrW-1:0]        vr;
        logic [CoefW-1:0]      ww;
        logic                  hez;
    } t_geo;

    // Sideband that travels with each entry.
    typedef struct packed {
        logic [IdxW-1:0] row;
        logic [IdxW-1:0] col;
        logic            last;
        logic            degen;
        logic            wsat;
        logic            qneg;
        logic            hez;
        logic            neg;
    } t_tag;

    typedef struct packed {
        logic [DiffW-1:0] prim_i;
        logic [DiffW-1:0] prim_j;
        logic [DiffW-1:0] sec_i;
        logic [DiffW-1:0] sec_j;
        logic [CoefW-1:0] coef;
        logic [CoefW-1:0] ww;
        logic [HeW-1:0]   he;
        logic [DenW-1:0]  den;
        t_tag             tag;
    } t_entry;

    // Sign-extended difference of two coordinates.
    function automatic logic [DiffW-1:0] sdiff(input logic [CoordW-1:0] a,
                                               input logic [CoordW-1:0] b);
        return {a[CoordW-1], a} - {b[CoordW-1], b};
    endfunction

endpackage

`default_nettype wire

// File: sv/cst_elem_setup.sv
// Per-element setup pipeline and the row/column sequencer that issues entries.
`default_nettype none

module cst_elem_setup import cst_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_tri_valid,
    output logic   o_tri_ready,
    input  t_tri   i_tri,
    input  logic   i_adv,
    output logic   o_ent_valid,
    output t_entry o_ent
);

    // Stage 1: edge vectors and material selection.
    logic                    r_s1_v;
    logic [2:0][DiffW-1:0]   r_s1_b, r_s1_c;
    logic [CoordW-1:0]       r_s1_e, r_s1_h;
    logic [VrW-1:0]          r_s1_vr;
    // Stage 2: determinant products and h*E.
    logic                    r_s2_v;
    logic signed [ProdW-1:0] r_s2_pa, r_s2_pb;
    logic [CoefW-1:0]        r_s2_upv;
    t_geo                    r_s2_g;
    // Stage 3: determinant.
    logic                    r_s3_v;
    logic signed [DetW-1:0]  r_s3_det;
    logic [CoefW-1:0]        r_s3_upv;
    t_geo                    r_s3_g;
    // Stage 4: magnitude of the determinant.
    logic                    r_s4_v;
    logic [AbsW-1:0]         r_s4_abs;
    logic                    r_s4_degen;
    logic [CoefW-1:0]        r_s4_upv;
    t_geo                    r_s4_g;
    // Stage 5: |det| * (1 + v).
    logic                    r_s5_v;
    logic [D1W-1:0]          r_s5_d1;
    logic                    r_s5_degen;
    t_geo                    r_s5_g;
    // Stage 6: full denominator.
    logic                    r_s6_v;
    logic [DenW-1:0]         r_s6_den;
    logic                    r_s6_degen;
    t_geo                    r_s6_g;
    // Element context held while its entries are issued.
    logic                    r_ctx_v;
    t_geo                    r_ctx_g;
    logic [DenW-1:0]         r_ctx_den;
    logic                    r_ctx_degen;
    logic [IdxW-1:0]         r_row, r_col;
    // Entry register feeding the arithmetic pipeline.
    logic                    r_ent_v;
    t_entry                  r_ent;

    logic w_adv1, w_adv2, w_adv3, w_adv4, w_adv5, w_adv6;
    logic w_issue, w_last, w_ctx_free;
    logic [CoordW-1:0] n_s1_e;
    logic [VrW-1:0]    n_s1_vr;
    logic [D1W+CoefW-1:0] w_dw;
    t_entry n_ent;

    function automatic logic [DiffW-1:0] pick(input logic [2:0][DiffW-1:0] v,
                                              input logic [1:0] n);
        logic [DiffW-1:0] r;
        unique case (n)
            2'd0: r = v[0];
            2'd1: r = v[1];
            default: r = v[2];
        endcase
        return r;
    endfunction

    // Sequencer handshake: a new element loads when the context is empty or its last entry issues.
    assign w_issue    = r_ctx_v && i_adv;
    assign w_last     = (r_row == DofLast) && (r_col == DofLast);
    assign w_ctx_free = !r_ctx_v || (w_issue && w_last);

    // Elastic advance chain of the setup stages.
    assign w_adv6 = !r_s6_v || w_ctx_free;
    assign w_adv5 = !r_s5_v || w_adv6;
    assign w_adv4 = !r_s4_v || w_adv5;
    assign w_adv3 = !r_s3_v || w_adv4;
    assign w_adv2 = !r_s2_v || w_adv3;
    assign w_adv1 = !r_s1_v || w_adv2;
    assign o_tri_ready = w_adv1;

    // Modulus by placement and ratio clamped to one half.
    always_comb begin
        unique case (i_tri.placement)
            PlaceBasal:  n_s1_e = i_cfg.mod_basal;
            PlaceApical: n_s1_e = i_cfg.mod_apical;
            default:     n_s1_e = i_cfg.mod_mid;
        endcase
        n_s1_vr = (i_cfg.poisson > HalfQ) ? HalfQ : i_cfg.poisson;
    end

    // Valid bits of the setup stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            if (w_adv1) r_s1_v <= i_tri_valid;
            if (w_adv2) r_s2_v <= r_s1_v;
            if (w_adv3) r_s3_v <= r_s2_v;
            if (w_adv4) r_s4_v <= r_s3_v;
            if (w_adv5) r_s5_v <= r_s4_v;
            if (w_adv6) r_s6_v <= r_s5_v;
        end
    end

    // Stage 1 data.
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_b[0] <= sdiff(i_tri.y[1], i_tri.y[2]);
            r_s1_b[1] <= sdiff(i_tri.y[2], i_tri.y[0]);
            r_s1_b[2] <= sdiff(i_tri.y[0], i_tri.y[1]);
            r_s1_c[0] <= sdiff(i_tri.x[2], i_tri.x[1]);
            r_s1_c[1] <= sdiff(i_tri.x[0], i_tri.x[2]);
            r_s1_c[2] <= sdiff(i_tri.x[1], i_tri.x[0]);
            r_s1_e    <= n_s1_e;
            r_s1_h    <= i_cfg.height;
            r_s1_vr   <= n_s1_vr;
        end
    end

    // Stage 2 data: det = c2*b1 - c1*b2.
    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_pa    <= $signed(r_s1_c[2]) * $signed(r_s1_b[1]);
            r_s2_pb    <= $signed(r_s1_c[1]) * $signed(r_s1_b[2]);
            r_s2_upv   <= OneQ + CoefW'(r_s1_vr);
            r_s2_g.b   <= r_s1_b;
            r_s2_g.c   <= r_s1_c;
            r_s2_g.he  <= HeW'(r_s1_h) * HeW'(r_s1_e);
            r_s2_g.umv <= OneQ - CoefW'(r_s1_vr);
            r_s2_g.vr  <= r_s1_vr;
            r_s2_g.ww  <= OneQ - {r_s1_vr, 1'b0};
            r_s2_g.hez <= 1'b0;
        end
    end

    // Stage 3 data; the zero flag of h*E is the lowest bit of the context.
    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_s3_det   <= DetW'(r_s2_pa) - DetW'(r_s2_pb);
            r_s3_upv   <= r_s2_upv;
            r_s3_g     <= {r_s2_g[$bits(t_geo)-1:1], (r_s2_g.he == '0)};
        end
    end

    // Stage 4 data.
    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_s4_abs   <= r_s3_det[DetW-1] ? AbsW'(-r_s3_det) : AbsW'(r_s3_det);
            r_s4_degen <= (r_s3_det == '0);
            r_s4_upv   <= r_s3_upv;
            r_s4_g     <= r_s3_g;
        end
    end

    // Stage 5 data.
    always_ff @(posedge i_clk) begin
        if (w_adv5) begin
            r_s5_d1    <= D1W'(r_s4_abs) * D1W'(r_s4_upv);
            r_s5_degen <= r_s4_degen;
            r_s5_g     <= r_s4_g;
        end
    end

    // Stage 6 data: the factor (1 - 2v) drops out when it is zero.
    assign w_dw = (D1W+CoefW)'(r_s5_d1) * (D1W+CoefW)'(r_s5_g.ww);

    always_ff @(posedge i_clk) begin
        if (w_adv6) begin
            if (r_s5_g.ww == '0) begin
                r_s6_den <= DenW'(r_s5_d1) << 2;
            end else begin
                r_s6_den <= DenW'(w_dw) << 2;
            end
            r_s6_degen <= r_s5_degen;
            r_s6_g     <= r_s5_g;
        end
    end

    // Context and row/column counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_v <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
        end else if (w_ctx_free) begin
            r_ctx_v <= r_s6_v;
            r_row   <= '0;
            r_col   <= '0;
        end else if (w_issue) begin
            if (r_col == DofLast) begin
                r_col <= '0;
                r_row <= r_row + 3'd1;
            end else begin
                r_col <= r_col + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctx_free && r_s6_v) begin
            r_ctx_g     <= r_s6_g;
            r_ctx_den   <= r_s6_den;
            r_ctx_degen <= r_s6_degen;
        end
    end

    // Entry operands: x rows use b as primary and c as secondary, y rows the reverse.
    always_comb begin
        n_ent.prim_i = r_row[0] ? pick(r_ctx_g.c, r_row[2:1]) : pick(r_ctx_g.b, r_row[2:1]);
        n_ent.sec_i  = r_row[0] ? pick(r_ctx_g.b, r_row[2:1]) : pick(r_ctx_g.c, r_row[2:1]);
        n_ent.prim_j = r_col[0] ? pick(r_ctx_g.c, r_col[2:1]) : pick(r_ctx_g.b, r_col[2:1]);
        n_ent.sec_j  = r_col[0] ? pick(r_ctx_g.b, r_col[2:1]) : pick(r_ctx_g.c, r_col[2:1]);
        n_ent.coef   = (r_row[0] == r_col[0]) ? r_ctx_g.umv : CoefW'(r_ctx_g.vr);
        n_ent.ww     = r_ctx_g.ww;
        n_ent.he     = r_ctx_g.he;
        n_ent.den    = r_ctx_den;
        n_ent.tag.row   = r_row;
        n_ent.tag.col   = r_col;
        n_ent.tag.last  = w_last;
        n_ent.tag.degen = r_ctx_degen;
        n_ent.tag.wsat  = 1'b0;
        n_ent.tag.qneg  = 1'b0;
        n_ent.tag.hez   = r_ctx_g.hez;
        n_ent.tag.neg   = 1'b0;
    end

    // Entry register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_v <= 1'b0;
        end else if (i_adv) begin
            r_ent_v <= r_ctx_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ent <= n_ent;
        end
    end

    assign o_ent_valid = r_ent_v;
    assign o_ent       = r_ent;

endmodule

`default_nettype wire

// File: sv/cst_entry_num.sv
// Entry pipeline: magnitude of the numerator h*E*(2Q + W*R); sign goes in tag.
`default_nettype none

module cst_entry_num import cst_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_ent_valid,
    input  t_entry          i_ent,
    output logic            o_num_valid,
    output logic [NumW-1:0] o_num,
    output logic [DenW-1:0] o_den,
    output t_tag            o_tag
);

    localparam int HalfW  = 32;
    localparam int ChunkW = 28;

    // Stage B: the two coordinate products.
    logic                    r_b_v;
    logic signed [ProdW-1:0] r_b_p1, r_b_p2;
    logic [CoefW-1:0]        r_b_coef, r_b_ww;
    logic [HeW-1:0]          r_b_he;
    logic [DenW-1:0]         r_b_den;
    t_tag                    r_b_tag;
    // Stage C: scaled terms.
    logic                    r_c_v;
    logic signed [TermW-1:0] r_c_t1, r_c_t2;
    logic signed [ProdW-1:0] r_c_p2;
    logic [CoefW-1:0]        r_c_ww;
    logic [HeW-1:0]          r_c_he;
    logic [DenW-1:0]         r_c_den;
    t_tag                    r_c_tag;
    // Stage D: bracket sum.
    logic                    r_d_v;
    logic signed [SumW-1:0]  r_d_s;
    logic [HeW-1:0]          r_d_he;
    logic [DenW-1:0]         r_d_den;
    t_tag                    r_d_tag;
    // Stage E: magnitude.
    logic                    r_e_v;
    logic [MagW-1:0]         r_e_mag;
    logic [HeW-1:0]          r_e_he;
    logic [DenW-1:0]         r_e_den;
    t_tag                    r_e_tag;
    // Stage F: partial products.
    logic                    r_f_v;
    logic [HalfW+ChunkW-1:0] r_f_pp [0:1][0:2];
    logic [DenW-1:0]         r_f_den;
    t_tag                    r_f_tag;
    // Stage G: half sums.
    logic                    r_g_v;
    logic [LoW-1:0]          r_g_part [0:1];
    logic [DenW-1:0]         r_g_den;
    t_tag                    r_g_tag;
    // Stage H: numerator magnitude.
    logic                    r_h_v;
    logic [NumW-1:0]         r_h_num;
    logic [DenW-1:0]         r_h_den;
    t_tag                    r_h_tag;

    // Valid bits move together with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (i_adv) begin
            r_b_v <= i_ent_valid;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // Primary and secondary products.
            r_b_p1   <= $signed(i_ent.prim_i) * $signed(i_ent.prim_j);
            r_b_p2   <= $signed(i_ent.sec_i) * $signed(i_ent.sec_j);
            r_b_coef <= i_ent.coef;
            r_b_ww   <= i_ent.ww;
            r_b_he   <= i_ent.he;
            r_b_den  <= i_ent.den;
            r_b_tag  <= i_ent.tag;

            // Q and W*R.
            r_c_t1  <= r_b_p1 * $signed({1'b0, r_b_coef});
            r_c_t2  <= r_b_p2 * $signed({1'b0, r_b_ww});
            r_c_p2  <= r_b_p2;
            r_c_ww  <= r_b_ww;
            r_c_he  <= r_b_he;
            r_c_den <= r_b_den;
            r_c_tag <= r_b_tag;

            // At a ratio of one half a nonzero Q saturates, else only R remains.
            if (r_c_ww == '0) begin
                r_d_s <= SumW'(r_c_p2);
            end else begin
                r_d_s <= (r_c_t1 <<< 1) + r_c_t2;
            end
            r_d_he        <= r_c_he;
            r_d_den       <= r_c_den;
            // The saturation flag and the sign of Q replace their tag bits.
            r_d_tag       <= {r_c_tag[$bits(t_tag)-1:4],
                              (r_c_ww == '0) && (r_c_t1 != '0),
                              r_c_t1[TermW-1],
                              r_c_tag[1:0]};

            // Sign and magnitude.
            r_e_mag     <= r_d_s[SumW-1] ? MagW'(-r_d_s) : MagW'(r_d_s);
            r_e_he      <= r_d_he;
            r_e_den     <= r_d_den;
            r_e_tag     <= {r_d_tag[$bits(t_tag)-1:1], r_d_s[SumW-1]};

            // Six narrow partial products of h*E by the magnitude.
            for (int a = 0; a < 2; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r_f_pp[a][k] <= (HalfW+ChunkW)'(r_e_he[a*HalfW +: HalfW])
                                  * (HalfW+ChunkW)'(r_e_mag[k*ChunkW +: ChunkW]);
                end
            end
            r_f_den <= r_e_den;
            r_f_tag <= r_e_tag;

            for (int a = 0; a < 2; a++) begin
                r_g_part[a] <= LoW'(r_f_pp[a][0])
                             + (LoW'(r_f_pp[a][1]) << ChunkW)
                             + (LoW'(r_f_pp[a][2]) << (2*ChunkW));
            end
            r_g_den <= r_f_den;
            r_g_tag <= r_f_tag;

            r_h_num <= NumW'(r_g_part[0]) + (NumW'(r_g_part[1]) << HalfW);
            r_h_den <= r_g_den;
            r_h_tag <= r_g_tag;
        end
    end

    assign o_num_valid = r_h_v;
    assign o_num       = r_h_num;
    assign o_den       = r_h_den;
    assign o_tag       = r_h_tag;

endmodule

`default_nettype wire

// File: sv/cst_round_div.sv
// Pipelined restoring divider with round-to-nearest and 48-bit saturation.
`default_nettype none

module cst_round_div import cst_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_num_valid,
    input  logic [NumW-1:0] i_num,
    input  logic [DenW-1:0] i_den,
    input  t_tag            i_tag,
    output logic            o_valid,
    output logic [ValW-1:0] o_value,
    output t_tag            o_tag
);

    // Rounding setup: quotient of (2n + d) by 2d.
    logic            r_i_v;
    logic [NxW-1:0]  r_i_nx;
    logic [DivW-1:0] r_i_dd;
    t_tag            r_i_tag;

    // Division stages; entry 0 holds the overflow test and first remainder.
    logic            r_v   [0:QuoW];
    logic            r_ovf [0:QuoW];
    logic [DivW-1:0] r_rem [0:QuoW];
    logic [DivW-1:0] r_dd  [0:QuoW];
    logic [QuoW-1:0] r_nlo [0:QuoW];
    logic [QuoW-1:0] r_quo [0:QuoW];
    t_tag            r_tag [0:QuoW];

    // Output register.
    logic            r_out_v;
    logic [ValW-1:0] r_out_val;
    t_tag            r_out_tag;
    logic [ValW-1:0] n_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_i_v <= i_num_valid;
            r_v[0] <= r_i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_i_nx  <= {i_num, 1'b0} + NxW'(i_den);
            r_i_dd  <= {i_den, 1'b0};
            r_i_tag <= i_tag;

            // A quotient of 2^47 or more saturates.
            r_ovf[0] <= (r_i_nx >= NxW'({r_i_dd, {QuoW{1'b0}}}));
            r_rem[0] <= r_i_nx[QuoW +: DivW];
            r_nlo[0] <= r_i_nx[QuoW-1:0];
            r_dd[0]  <= r_i_dd;
            r_quo[0] <= '0;
            r_tag[0] <= r_i_tag;
        end
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < QuoW; k++) begin : g_step
        logic [DivW:0] w_t;
        logic          w_ge;

        assign w_t  = {r_rem[k], r_nlo[k][QuoW-1]};
        assign w_ge = (w_t >= {1'b0, r_dd[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (w_ge) begin
                    r_rem[k+1] <= DivW'(w_t - {1'b0, r_dd[k]});
                end else begin
                    r_rem[k+1] <= DivW'(w_t);
                end
                r_nlo[k+1] <= r_nlo[k] << 1;
                r_quo[k+1] <= {r_quo[k][QuoW-2:0], w_ge};
                r_dd[k+1]  <= r_dd[k];
                r_ovf[k+1] <= r_ovf[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    // Final value with the zero-area and half-ratio special cases.
    always_comb begin
        priority if (r_tag[QuoW].degen) begin
            n_out_val = '0;
        end else if (r_tag[QuoW].wsat) begin
            if (r_tag[QuoW].hez) begin
                n_out_val = '0;
            end else begin
                n_out_val = r_tag[QuoW].qneg ? ValMin : ValMax;
            end
        end else if (r_ovf[QuoW]) begin
            n_out_val = r_tag[QuoW].neg ? ValMin : ValMax;
        end else if (r_tag[QuoW].neg) begin
            n_out_val = ValW'(0) - {1'b0, r_quo[QuoW]};
        end else begin
            n_out_val = {1'b0, r_quo[QuoW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_adv) begin
            r_out_v <= r_v[QuoW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out_val <= n_out_val;
            r_out_tag <= r_tag[QuoW];
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_out_val;
    assign o_tag   = r_out_tag;

endmodule

`default_nettype wire

// File: sv/cst_element_stiffness_unit.sv
// Plane-stress triangle stiffness unit: one triangle in, 36 stiffness entries out, row by row.
// Each accepted triangle produces the 6x6 entries k(row,col) on the result port, one per
// cycle while results flow, and the next element context loads when the last entry of the
// previous one issues; the triangle rate is set by the single result port, as every other
// part of the pipeline handles one entry per clock. The first entry passes through six setup
// stages, the element context and entry registers, seven stages that build the numerator, two
// rounding stages, a 47-stage restoring divider (one quotient bit per stage) and the output
// register. A stall on the result side holds the whole entry pipeline in place. Configuration
// writes take effect for triangles accepted afterwards and are meant to be made while the
// unit is idle.
`default_nettype none

module cst_element_stiffness_unit import cst_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [IdxW-1:0]        i_cfg_index,
    input  logic [CoordW-1:0]      i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [CoordW-1:0] i_node0_x,
    input  logic signed [CoordW-1:0] i_node0_y,
    input  logic signed [CoordW-1:0] i_node1_x,
    input  logic signed [CoordW-1:0] i_node1_y,
    input  logic signed [CoordW-1:0] i_node2_x,
    input  logic signed [CoordW-1:0] i_node2_y,
    input  logic [1:0]             i_placement,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [IdxW-1:0]        o_row_index,
    output logic [IdxW-1:0]        o_col_index,
    output logic signed [ValW-1:0] o_stiffness_value,
    output logic                   o_degenerate,
    output logic                   o_last_entry
);

    t_cfg            r_cfg;
    t_tri            w_tri;
    logic            w_adv;
    logic            w_ent_v;
    t_entry          w_ent;
    logic            w_num_v;
    logic [NumW-1:0] w_num;
    logic [DenW-1:0] w_den;
    t_tag            w_num_tag;
    logic            w_out_v;
    logic [ValW-1:0] w_out_val;
    t_tag            w_out_tag;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mod_apical <= 32'd655360;
            r_cfg.mod_basal  <= 32'd655360;
            r_cfg.mod_mid    <= 32'd655360;
            r_cfg.poisson    <= 16'd19661;
            r_cfg.height     <= 32'd65536;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CfgModApical: r_cfg.mod_apical <= i_cfg_wdata;
                CfgModBasal:  r_cfg.mod_basal  <= i_cfg_wdata;
                CfgModMid:    r_cfg.mod_mid    <= i_cfg_wdata;
                CfgPoisson:   r_cfg.poisson    <= i_cfg_wdata[VrW-1:0];
                CfgHeight:    r_cfg.height     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Triangle request bundle.
    assign w_tri.x[0]      = i_node0_x;
    assign w_tri.y[0]      = i_node0_y;
    assign w_tri.x[1]      = i_node1_x;
    assign w_tri.y[1]      = i_node1_y;
    assign w_tri.x[2]      = i_node2_x;
    assign w_tri.y[2]      = i_node2_y;
    assign w_tri.placement = i_placement;

    // The entry pipeline moves whenever the output register is free or being taken.
    assign w_adv = !w_out_v || i_out_ready;

    cst_elem_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_tri_valid (i_in_valid),
        .o_tri_ready (o_in_ready),
        .i_tri       (w_tri),
        .i_adv       (w_adv),
        .o_ent_valid (w_ent_v),
        .o_ent       (w_ent)
    );

    cst_entry_num u_num (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_ent_valid (w_ent_v),
        .i_ent       (w_ent),
        .o_num_valid (w_num_v),
        .o_num       (w_num),
        .o_den       (w_den),
        .o_tag       (w_num_tag)
    );

    cst_round_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_num_valid (w_num_v),
        .i_num       (w_num),
        .i_den       (w_den),
        .i_tag       (w_num_tag),
        .o_valid     (w_out_v),
        .o_value     (w_out_val),
        .o_tag       (w_out_tag)
    );

    assign o_out_valid       = w_out_v;
    assign o_row_index       = w_out_tag.row;
    assign o_col_index       = w_out_tag.col;
    assign o_stiffness_value = w_out_val;
    assign o_degenerate      = w_out_tag.degen;
    assign o_last_entry      = w_out_tag.last;

endmodule

`default_nettype wire

// File: bench/cst_element_stiffness_unit_test.sv
// Self-checking testbench of the plane-stress triangle stiffness unit.
`timescale 1ns / 100ps

module cst_element_stiffness_unit_test;
    import cst_pkg::*;

    typedef logic signed [191:0] wide_t;

    // One stiffness entry as it should leave the unit.
    typedef struct {
        logic [IdxW-1:0] row;
        logic [IdxW-1:0] col;
        logic [ValW-1:0] value;
        logic            degen;
        logic            last;
    } entry_t;

    // One row of the directed stimulus; flat rows carry their known all-zero answer.
    typedef struct {
        logic [CoordW-1:0] x0, y0, x1, y1, x2, y2;
        logic [1:0]        place;
        bit                flat;
    } tri_row_t;

    localparam int CfgMax = 32'hFFFF_FFFF;
    localparam logic [31:0] QOne = 32'd65536;
    localparam logic [31:0] CMin = 32'h8000_0000;
    localparam logic [31:0] CMax = 32'h7FFF_FFFF;
    localparam int WatchLimit = 4000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [IdxW-1:0]        i_cfg_index = '0;
    logic [CoordW-1:0]      i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic signed [CoordW-1:0] i_node0_x = '0, i_node0_y = '0;
    logic signed [CoordW-1:0] i_node1_x = '0, i_node1_y = '0;
    logic signed [CoordW-1:0] i_node2_x = '0, i_node2_y = '0;
    logic [1:0]             i_placement = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [IdxW-1:0]        o_row_index, o_col_index;
    logic signed [ValW-1:0] o_stiffness_value;
    logic                   o_degenerate, o_last_entry;

    cst_element_stiffness_unit dut (.*);

    // Clock: 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [31:0] mod_apical = 32'd655360, mod_basal = 32'd655360, mod_mid = 32'd655360;
    logic [15:0] poisson = 16'd19661;
    logic [31:0] height = 32'd65536;

    entry_t expected_entries[$];
    int     mismatches = 0;
    int     entries_seen = 0;
    int     idle_cycles = 0;
    bit     steady = 1'b0;

    // Computes the 36 stiffness entries of one triangle and queues them.
    function automatic void predict_stiffness(logic [CoordW-1:0] xs[3], logic [CoordW-1:0] ys[3],
                                              logic [1:0] place);
        wide_t x[3], y[3], p0[6], p1[6], p2[6];
        wide_t det, absdet, he, uv, ww, vr, den, s1, s2, r, q, num, mag, quo;
        logic [31:0] e;
        entry_t en;
        bit degen, neg;
        int n1, n2;
        for (int n = 0; n < 3; n++) begin
            x[n] = $signed(xs[n]);
            y[n] = $signed(ys[n]);
        end
        e = (place == PlaceBasal) ? mod_basal : (place == PlaceApical) ? mod_apical : mod_mid;
        vr = (poisson > HalfQ) ? wide_t'(HalfQ) : wide_t'(poisson);
        for (int n = 0; n < 3; n++) begin
            n1 = (n + 1) % 3;
            n2 = (n + 2) % 3;
            p0[2*n] = y[n1] - y[n2];   p1[2*n] = 0;               p2[2*n] = x[n2] - x[n1];
            p0[2*n+1] = 0;             p1[2*n+1] = x[n2] - x[n1]; p2[2*n+1] = y[n1] - y[n2];
        end
        det = (x[1] - x[0]) * (y[2] - y[0]) - (x[2] - x[0]) * (y[1] - y[0]);
        degen = (det == 0);
        absdet = (det < 0) ? -det : det;
        he = wide_t'(height) * wide_t'(e);
        uv = 65536 - vr;
        ww = 65536 - 2 * vr;
        den = 4 * absdet * (65536 + vr) * ((ww != 0) ? ww : wide_t'(1));
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 6; j++) begin
                en.row = IdxW'(i);
                en.col = IdxW'(j);
                en.degen = degen;
                en.last = (en.row == DofLast) && (en.col == DofLast);
                en.value = '0;
                if (!degen) begin
                    s1 = p0[i] * p0[j] + p1[i] * p1[j];
                    s2 = p0[i] * p1[j] + p1[i] * p0[j];
                    r = p2[i] * p2[j];
                    q = uv * s1 + vr * s2;
                    // Ratio at one half: nonzero shear-free part goes straight to the rail unless h*E is zero.
                    if (ww == 0 && q != 0) begin
                        if (he != 0) en.value = (q < 0) ? ValMin : ValMax;
                    end else begin
                        num = (ww == 0) ? he * r : he * (2 * q + ww * r);
                        neg = (num < 0);
                        mag = neg ? -num : num;
                        quo = (2 * mag + den) / (2 * den);
                        if (neg) en.value = (quo >= (wide_t'(1) <<< 47)) ? ValMin : ValW'(-quo);
                        else en.value = (quo > wide_t'(ValMax)) ? ValMax : ValW'(quo);
                    end
                end
                expected_entries.push_back(en);
            end
        end
    endfunction

    // Writes one register and updates the shadow copy.
    task automatic write_reg(logic [IdxW-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CfgModApical: mod_apical = data;
            CfgModBasal:  mod_basal = data;
            CfgModMid:    mod_mid = data;
            CfgPoisson:   poisson = data[15:0];
            CfgHeight:    height = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Waits until every expected entry has arrived and the pipeline has drained.
    task automatic wait_drained();
        while (expected_entries.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        if (steady) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Offers one triangle request and returns once it is accepted.
    task automatic send_triangle(logic [CoordW-1:0] xs[3], logic [CoordW-1:0] ys[3],
                                 logic [1:0] place, bit flat);
        int gap;
        entry_t en;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_node0_x <= xs[0]; i_node0_y <= ys[0];
        i_node1_x <= xs[1]; i_node1_y <= ys[1];
        i_node2_x <= xs[2]; i_node2_y <= ys[2];
        i_placement <= place;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (flat) begin
            for (int k = 0; k < 36; k++) begin
                en.row = IdxW'(k / 6);
                en.col = IdxW'(k % 6);
                en.value = '0;
                en.degen = 1'b1;
                en.last = (k == 35);
                expected_entries.push_back(en);
            end
        end else begin
            predict_stiffness(xs, ys, place);
        end
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 2**20)) - 2**19);
            1: return 32'($signed($urandom_range(0, 2**26)) - 2**25);
            default: return $urandom();
        endcase
    endfunction

    // Random triangle: mostly moderate sizes, some full range, some collapsed.
    task automatic send_random();
        logic [CoordW-1:0] xs[3], ys[3];
        int mode, shape;
        mode = $urandom_range(0, 9);
        mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
        for (int n = 0; n < 3; n++) begin
            xs[n] = rand_coord(mode);
            ys[n] = rand_coord(mode);
        end
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            xs[2] = xs[0]; ys[2] = ys[0];
        end else if (shape == 1) begin
            xs[1] = xs[0]; xs[2] = xs[0];
        end else if (shape == 2) begin
            // Point on the line through the first two nodes.
            xs[2] = 2 * xs[1] - xs[0]; ys[2] = 2 * ys[1] - ys[0];
        end
        send_triangle(xs, ys, 2'($urandom_range(0, 3)), 1'b0);
    endtask

    // Result side: checks each entry and paces ready, with one long hold-off.
    initial begin
        bit held = 1'b0;
        entry_t en;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                entries_seen++;
                if (expected_entries.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected entry row %0d col %0d value %h",
                                 o_row_index, o_col_index, o_stiffness_value);
                end else begin
                    en = expected_entries.pop_front();
                    if (o_row_index !== en.row || o_col_index !== en.col ||
                        o_stiffness_value !== en.value || o_degenerate !== en.degen ||
                        o_last_entry !== en.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: exp r%0d c%0d v%h d%b l%b, got r%0d c%0d v%h d%b l%b",
                                     en.row, en.col, en.value, en.degen, en.last,
                                     o_row_index, o_col_index, o_stiffness_value,
                                     o_degenerate, o_last_entry);
                    end
                end
            end
            if (!held && entries_seen >= 2500) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (steady || !i_rst_n) begin
                i_out_ready <= i_rst_n;
            end else if (i_out_ready && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 3)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted request on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    tri_row_t directed[12];
    logic [31:0] phase_cfg[8][5];

    // Main sequence: directed rows, then random phases under changing settings.
    initial begin
        logic [CoordW-1:0] xs[3], ys[3];
        directed[0]  = '{0, 0, QOne, 0, 0, QOne, 2'd0, 0};
        directed[1]  = '{0, 0, QOne, 0, 0, QOne, 2'd1, 0};
        directed[2]  = '{0, 0, QOne, 0, 0, QOne, 2'd2, 0};
        directed[3]  = '{0, 0, 0, QOne, QOne, 0, 2'd3, 0};
        directed[4]  = '{QOne, QOne, QOne, QOne, QOne, QOne, 2'd0, 1};
        directed[5]  = '{0, 0, QOne, QOne, 2 * QOne, 2 * QOne, 2'd1, 1};
        directed[6]  = '{0, 0, 0, 0, 0, 0, 2'd2, 1};
        directed[7]  = '{CMin, CMin, CMax, CMin, CMin, CMax, 2'd0, 0};
        directed[8]  = '{CMax, CMax, CMin, CMax, CMax, CMin, 2'd1, 0};
        directed[9]  = '{0, 0, 1, 0, 0, 1, 2'd2, 0};
        directed[10] = '{-QOne, -3 * QOne, -5 * QOne, 7, 32'hFFFF_0001, 9 * QOne, 2'd3, 0};
        directed[11] = '{CMin, CMin, CMin, CMin, CMin, CMin, 2'd0, 1};
        // apical, basal, mid, ratio, height
        phase_cfg[0] = '{CfgMax, CfgMax, CfgMax, 0, CfgMax};
        phase_cfg[1] = '{0, 0, 0, 16'd20000, 1};
        phase_cfg[2] = '{32'd655360, 32'd1310720, 32'd196608, 16'd32768, 32'd65536};
        phase_cfg[3] = '{32'd65536, 32'd131072, 32'd32768, 16'hFFFF, 32'd131072};
        phase_cfg[4] = '{32'd7, 32'd655360, 32'd100, 16'd32767, 32'd1};
        phase_cfg[5] = '{$urandom(), $urandom(), $urandom(), $urandom_range(0, 65535), $urandom()};
        phase_cfg[6] = '{$urandom_range(0, 2**24), $urandom_range(0, 2**24), $urandom(),
                         $urandom_range(0, 32768), $urandom_range(1, 2**20)};
        phase_cfg[7] = '{$urandom(), 0, $urandom(), 16'd1, $urandom_range(1, 2**31)};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            xs = '{directed[k].x0, directed[k].x1, directed[k].x2};
            ys = '{directed[k].y0, directed[k].y1, directed[k].y2};
            send_triangle(xs, ys, directed[k].place, directed[k].flat);
        end

        for (int ph = 0; ph < 8; ph++) begin
            i_in_valid <= 1'b0;
            wait_drained();
            for (int r = 0; r < 5; r++) write_reg(IdxW'(r), phase_cfg[ph][r]);
            // Indexes past the last register must be ignored.
            if (ph == 2) for (int r = 5; r < 8; r++) write_reg(IdxW'(r), $urandom());
            steady = (ph == 4);
            for (int k = 0; k < 37; k++) send_random();
        end

        i_in_valid <= 1'b0;
        wait_drained();
        if (mismatches == 0 && expected_entries.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
sv/cst_pkg.sv
sv/cst_elem_setup.sv
sv/cst_entry_num.sv
sv/cst_round_div.sv
sv/cst_element_stiffness_unit.sv
bench/cst_element_stiffness_unit_test.sv
